### src/staggered_velocity_predictor_core_assert.svh
`ifndef STAGGERED_VELOCITY_PREDICTOR_CORE_ASSERT_SVH
`define STAGGERED_VELOCITY_PREDICTOR_CORE_ASSERT_SVH

// same-cycle implication
`define SVP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("svp assertion failed");

// next-cycle implication
`define SVP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("svp assertion failed");

`endif

### src/svp_pkg.sv
package svp_pkg;

	localparam int NSTG = 10;
	localparam int DW = 32;
	localparam int CW = 31;
	localparam int CFG_IW = 2;
	localparam int D2W = 2 * CW - 16;

	localparam logic [CFG_IW-1:0] REG_INV_DX = 2'd0;
	localparam logic [CFG_IW-1:0] REG_INV_DY = 2'd1;
	localparam logic [CFG_IW-1:0] REG_VISC = 2'd2;
	localparam logic [CFG_IW-1:0] REG_TSTEP = 2'd3;

	localparam logic [CW-1:0] RST_INV_D = 31'd65536;
	localparam logic [CW-1:0] RST_VISC = 31'd65536;
	localparam logic [CW-1:0] RST_TSTEP = 31'd655;

	typedef struct packed {
		logic signed [DW-1:0] u_c;
		logic signed [DW-1:0] u_w;
		logic signed [DW-1:0] u_e;
		logic signed [DW-1:0] u_s;
		logic signed [DW-1:0] u_n;
		logic signed [DW-1:0] u_se;
		logic signed [DW-1:0] v_c;
		logic signed [DW-1:0] v_w;
		logic signed [DW-1:0] v_e;
		logic signed [DW-1:0] v_s;
		logic signed [DW-1:0] v_n;
		logic signed [DW-1:0] v_nw;
	} cell_t;

	typedef struct packed {
		logic signed [DW-1:0] u_pred;
		logic signed [DW-1:0] v_pred;
		logic saturated;
	} pred_t;

	typedef struct packed {
		logic [D2W-1:0] dx2;
		logic [D2W-1:0] dy2;
		logic [CW-2:0] hdx;
		logic [CW-2:0] hdy;
		logic [CW-1:0] visc;
		logic [CW-1:0] tstep;
	} coef_t;

endpackage

### src/staggered_velocity_predictor_core.sv
// channel | direction | handshake                | payload
// cell    | in        | cell_valid, cell_ready   | stencil (svp_pkg::cell_t)
// pred    | out       | pred_valid, pred_ready   | pred (svp_pkg::pred_t)
// cfg     | in        | cfg_wr_en                | cfg_index, cfg_data
//
// pred_valid rises once a cell has passed the ten-stage multiply pipeline,
// one cell per cycle while pred_ready does not stall it, products split in 32-bit halves
// reset clears all stage valid bits and loads the default coefficients
// each stage holds while it is full and the one after it cannot take data, empty stages close up under a stall
// cell_ready stays high while any stage is empty, so a waiting result does not block input
module staggered_velocity_predictor_core (
	input logic clk,
	input logic arst_n,
	input logic cell_valid,
	output logic cell_ready,
	input svp_pkg::cell_t stencil,
	output logic pred_valid,
	input logic pred_ready,
	output svp_pkg::pred_t pred,
	input logic cfg_wr_en,
	input logic [svp_pkg::CFG_IW-1:0] cfg_index,
	input logic [svp_pkg::CW-1:0] cfg_data
);
	import svp_pkg::*;

	logic [NSTG-1:0] stg_en;
	coef_t coef;

	svp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cell_valid(cell_valid),
		.cell_ready(cell_ready),
		.pred_valid(pred_valid),
		.pred_ready(pred_ready),
		.stg_en(stg_en)
	);

	svp_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.coef(coef)
	);

	svp_dpath u_dpath (
		.clk(clk),
		.stg_en(stg_en),
		.coef(coef),
		.stencil(stencil),
		.pred(pred)
	);

endmodule

### src/svp_cfg.sv
module svp_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [svp_pkg::CFG_IW-1:0] cfg_index,
	input logic [svp_pkg::CW-1:0] cfg_data,
	output svp_pkg::coef_t coef
);
	import svp_pkg::*;

	localparam int PW = 2 * CW;
	localparam logic [PW-1:0] RST_SQ = PW'(RST_INV_D) * PW'(RST_INV_D);

	logic [PW-1:0] sq;
	logic [D2W-1:0] dx2_q, dy2_q;
	logic [CW-2:0] hdx_q, hdy_q;
	logic [CW-1:0] visc_q, tstep_q;

	// square of the written inverse spacing, taken at write time
	assign sq = PW'(cfg_data) * PW'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx2_q <= RST_SQ[PW-1:16];
			dy2_q <= RST_SQ[PW-1:16];
			hdx_q <= RST_INV_D[CW-1:1];
			hdy_q <= RST_INV_D[CW-1:1];
			visc_q <= RST_VISC;
			tstep_q <= RST_TSTEP;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_INV_DX: begin
					dx2_q <= sq[PW-1:16];
					hdx_q <= cfg_data[CW-1:1];
				end
				REG_INV_DY: begin
					dy2_q <= sq[PW-1:16];
					hdy_q <= cfg_data[CW-1:1];
				end
				REG_VISC: begin
					visc_q <= cfg_data;
				end
				REG_TSTEP: begin
					tstep_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign coef.dx2 = dx2_q;
	assign coef.dy2 = dy2_q;
	assign coef.hdx = hdx_q;
	assign coef.hdy = hdy_q;
	assign coef.visc = visc_q;
	assign coef.tstep = tstep_q;

endmodule

### src/svp_ctrl.sv
`include "staggered_velocity_predictor_core_assert.svh"

module svp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cell_valid,
	output logic cell_ready,
	output logic pred_valid,
	input logic pred_ready,
	output logic [svp_pkg::NSTG-1:0] stg_en
);
	import svp_pkg::*;

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0] rdy;

	// a stage takes new data when it is empty or its content moves on
	assign rdy[NSTG] = pred_ready;
	for (genvar k = 0; k < NSTG; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign stg_en = rdy[NSTG-1:0];
	assign cell_ready = rdy[0];
	assign pred_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (stg_en & {vld_q[NSTG-2:0], cell_valid}) | (~stg_en & vld_q);
		end
	end

	`SVP_ASSERT_IMP(a_conserve, clk, arst_n, $past(arst_n), $countones(vld_q) == $past($countones(vld_q)) + $past(cell_valid && cell_ready) - $past(pred_valid && pred_ready))
	`SVP_ASSERT_NXT(a_enter, clk, arst_n, cell_valid && cell_ready, vld_q[0])
	`SVP_ASSERT_IMP(a_full_stall, clk, arst_n, !cell_ready, &vld_q)

endmodule

### src/svp_dpath.sv
module svp_dpath (
	input logic clk,
	input logic [svp_pkg::NSTG-1:0] stg_en,
	input svp_pkg::coef_t coef,
	input svp_pkg::cell_t stencil,
	output svp_pkg::pred_t pred
);
	import svp_pkg::*;

	typedef struct packed {
		logic ovf;
		logic signed [63:0] val;
	} sat64_t;

	typedef struct packed {
		logic ovf;
		logic signed [DW-1:0] val;
	} sat32_t;

	localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};
	localparam logic signed [DW-1:0] MAX32 = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MIN32 = {1'b1, {(DW-1){1'b0}}};

	// recombine two partial products and drop 16 fraction bits
	function automatic logic signed [63:0] join_shr(input logic signed [79:0] hi,
		input logic signed [79:0] lo);
		logic signed [79:0] s;
		s = (hi <<< 32) + lo;
		return s[79:16];
	endfunction

	function automatic sat64_t join_sat(input logic signed [95:0] hi,
		input logic signed [95:0] lo);
		logic signed [95:0] s;
		logic signed [79:0] q;
		sat64_t r;
		s = (hi <<< 32) + lo;
		q = s[95:16];
		r.ovf = (q[79:63] != {17{q[79]}});
		r.val = r.ovf ? (q[79] ? MIN64 : MAX64) : q[63:0];
		return r;
	endfunction

	function automatic sat64_t sat65(input logic signed [64:0] x);
		sat64_t r;
		r.ovf = x[64] ^ x[63];
		r.val = r.ovf ? (x[64] ? MIN64 : MAX64) : x[63:0];
		return r;
	endfunction

	function automatic sat32_t sat_out(input logic signed [64:0] x);
		sat32_t r;
		r.ovf = (x[64:DW-1] != {(66-DW){x[64]}});
		r.val = r.ovf ? (x[64] ? MIN32 : MAX32) : x[DW-1:0];
		return r;
	endfunction

	// coefficient operands as signed values
	logic signed [32:0] dx2_lo, dy2_lo;
	logic signed [D2W-32:0] dx2_hi, dy2_hi;
	logic signed [CW-1:0] hdx_s, hdy_s;
	logic signed [CW:0] visc_s, tstep_s;

	assign dx2_lo = {1'b0, coef.dx2[31:0]};
	assign dy2_lo = {1'b0, coef.dy2[31:0]};
	assign dx2_hi = {1'b0, coef.dx2[D2W-1:32]};
	assign dy2_hi = {1'b0, coef.dy2[D2W-1:32]};
	assign hdx_s = {1'b0, coef.hdx};
	assign hdy_s = {1'b0, coef.hdy};
	assign visc_s = {1'b0, coef.visc};
	assign tstep_s = {1'b0, coef.tstep};

	// stage 1: stencil differences and cross averages
	logic signed [33:0] sum_u4, sum_v4;
	logic signed [33:0] lux_s1, luy_s1, lvx_s1, lvy_s1;
	logic signed [32:0] dux_s1, duy_s1, dvx_s1, dvy_s1;
	logic signed [DW-1:0] avgu_s1, avgv_s1, uc_s1, vc_s1;

	assign sum_u4 = 34'(stencil.u_s) + 34'(stencil.u_c) + 34'(stencil.u_se)
		+ 34'(stencil.u_e);
	assign sum_v4 = 34'(stencil.v_w) + 34'(stencil.v_c) + 34'(stencil.v_nw)
		+ 34'(stencil.v_n);

	always_ff @(posedge clk) begin
		if (stg_en[0]) begin
			lux_s1 <= 34'(stencil.u_w) + 34'(stencil.u_e) - (34'(stencil.u_c) <<< 1);
			luy_s1 <= 34'(stencil.u_s) + 34'(stencil.u_n) - (34'(stencil.u_c) <<< 1);
			lvx_s1 <= 34'(stencil.v_w) + 34'(stencil.v_e) - (34'(stencil.v_c) <<< 1);
			lvy_s1 <= 34'(stencil.v_s) + 34'(stencil.v_n) - (34'(stencil.v_c) <<< 1);
			dux_s1 <= 33'(stencil.u_e) - 33'(stencil.u_w);
			duy_s1 <= 33'(stencil.u_n) - 33'(stencil.u_s);
			dvx_s1 <= 33'(stencil.v_e) - 33'(stencil.v_w);
			dvy_s1 <= 33'(stencil.v_n) - 33'(stencil.v_s);
			avgu_s1 <= sum_u4[33:2];
			avgv_s1 <= sum_v4[33:2];
			uc_s1 <= stencil.u_c;
			vc_s1 <= stencil.v_c;
		end
	end

	// stage 2: laplacian partial products and first advection products
	logic signed [66:0] plux_lo_s2, pluy_lo_s2, plvx_lo_s2, plvy_lo_s2;
	logic signed [48:0] plux_hi_s2, pluy_hi_s2, plvx_hi_s2, plvy_hi_s2;
	logic signed [63:0] ta1u_s2;
	logic signed [64:0] ma2u_s2, ma1v_s2, ma2v_s2;
	logic signed [DW-1:0] uc_s2, vc_s2;

	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			plux_lo_s2 <= 67'(lux_s1) * 67'(dx2_lo);
			plux_hi_s2 <= 49'(lux_s1) * 49'(dx2_hi);
			pluy_lo_s2 <= 67'(luy_s1) * 67'(dy2_lo);
			pluy_hi_s2 <= 49'(luy_s1) * 49'(dy2_hi);
			plvx_lo_s2 <= 67'(lvx_s1) * 67'(dx2_lo);
			plvx_hi_s2 <= 49'(lvx_s1) * 49'(dx2_hi);
			plvy_lo_s2 <= 67'(lvy_s1) * 67'(dy2_lo);
			plvy_hi_s2 <= 49'(lvy_s1) * 49'(dy2_hi);
			ta1u_s2 <= 64'(dux_s1) * 64'(hdx_s);
			ma2u_s2 <= 65'(avgv_s1) * 65'(duy_s1);
			ma1v_s2 <= 65'(avgu_s1) * 65'(dvx_s1);
			ma2v_s2 <= 65'(vc_s1) * 65'(dvy_s1);
			uc_s2 <= uc_s1;
			vc_s2 <= vc_s1;
		end
	end

	// stage 3: laplacian terms, second advection partial products
	logic signed [46:0] t1u;
	logic signed [48:0] m2u, m1v, m2v;
	logic signed [32:0] t1u_lo, m2u_lo, m1v_lo, m2v_lo;
	logic signed [14:0] t1u_hi;
	logic signed [16:0] m2u_hi, m1v_hi, m2v_hi;
	logic signed [63:0] lux_s3, luy_s3, lvx_s3, lvy_s3;
	logic signed [64:0] pa1u_lo_s3;
	logic signed [46:0] pa1u_hi_s3;
	logic signed [63:0] pa2u_lo_s3, pa1v_lo_s3, pa2v_lo_s3;
	logic signed [47:0] pa2u_hi_s3, pa1v_hi_s3, pa2v_hi_s3;
	logic signed [DW-1:0] uc_s3, vc_s3;

	assign t1u = ta1u_s2[62:16];
	assign m2u = ma2u_s2[64:16];
	assign m1v = ma1v_s2[64:16];
	assign m2v = ma2v_s2[64:16];
	assign t1u_lo = {1'b0, t1u[31:0]};
	assign t1u_hi = t1u[46:32];
	assign m2u_lo = {1'b0, m2u[31:0]};
	assign m2u_hi = m2u[48:32];
	assign m1v_lo = {1'b0, m1v[31:0]};
	assign m1v_hi = m1v[48:32];
	assign m2v_lo = {1'b0, m2v[31:0]};
	assign m2v_hi = m2v[48:32];

	always_ff @(posedge clk) begin
		if (stg_en[2]) begin
			lux_s3 <= join_shr(80'(plux_hi_s2), 80'(plux_lo_s2));
			luy_s3 <= join_shr(80'(pluy_hi_s2), 80'(pluy_lo_s2));
			lvx_s3 <= join_shr(80'(plvx_hi_s2), 80'(plvx_lo_s2));
			lvy_s3 <= join_shr(80'(plvy_hi_s2), 80'(plvy_lo_s2));
			pa1u_lo_s3 <= 65'(uc_s2) * 65'(t1u_lo);
			pa1u_hi_s3 <= 47'(uc_s2) * 47'(t1u_hi);
			pa2u_lo_s3 <= 64'(m2u_lo) * 64'(hdy_s);
			pa2u_hi_s3 <= 48'(m2u_hi) * 48'(hdy_s);
			pa1v_lo_s3 <= 64'(m1v_lo) * 64'(hdx_s);
			pa1v_hi_s3 <= 48'(m1v_hi) * 48'(hdx_s);
			pa2v_lo_s3 <= 64'(m2v_lo) * 64'(hdy_s);
			pa2v_hi_s3 <= 48'(m2v_hi) * 48'(hdy_s);
			uc_s3 <= uc_s2;
			vc_s3 <= vc_s2;
		end
	end

	// stage 4: laplacian sums, advection terms
	sat64_t rsu, rsv;
	logic signed [63:0] su_s4, sv_s4, a1u_s4, a2u_s4, a1v_s4, a2v_s4;
	logic fl_s4;
	logic signed [DW-1:0] uc_s4, vc_s4;

	assign rsu = sat65(65'(lux_s3) + 65'(luy_s3));
	assign rsv = sat65(65'(lvx_s3) + 65'(lvy_s3));

	always_ff @(posedge clk) begin
		if (stg_en[3]) begin
			su_s4 <= rsu.val;
			sv_s4 <= rsv.val;
			fl_s4 <= rsu.ovf | rsv.ovf;
			a1u_s4 <= join_shr(80'(pa1u_hi_s3), 80'(pa1u_lo_s3));
			a2u_s4 <= join_shr(80'(pa2u_hi_s3), 80'(pa2u_lo_s3));
			a1v_s4 <= join_shr(80'(pa1v_hi_s3), 80'(pa1v_lo_s3));
			a2v_s4 <= join_shr(80'(pa2v_hi_s3), 80'(pa2v_lo_s3));
			uc_s4 <= uc_s3;
			vc_s4 <= vc_s3;
		end
	end

	// stage 5: viscosity partial products, advection sum
	logic signed [32:0] su_lo, sv_lo;
	logic signed [31:0] su_hi, sv_hi;
	logic signed [64:0] pdu_lo_s5, pdv_lo_s5;
	logic signed [63:0] pdu_hi_s5, pdv_hi_s5, a12u_s5, a12v_s5;
	logic fl_s5;
	logic signed [DW-1:0] uc_s5, vc_s5;

	assign su_lo = {1'b0, su_s4[31:0]};
	assign su_hi = su_s4[63:32];
	assign sv_lo = {1'b0, sv_s4[31:0]};
	assign sv_hi = sv_s4[63:32];

	always_ff @(posedge clk) begin
		if (stg_en[4]) begin
			pdu_lo_s5 <= 65'(visc_s) * 65'(su_lo);
			pdu_hi_s5 <= 64'(visc_s) * 64'(su_hi);
			pdv_lo_s5 <= 65'(visc_s) * 65'(sv_lo);
			pdv_hi_s5 <= 64'(visc_s) * 64'(sv_hi);
			a12u_s5 <= a1u_s4 + a2u_s4;
			a12v_s5 <= a1v_s4 + a2v_s4;
			fl_s5 <= fl_s4;
			uc_s5 <= uc_s4;
			vc_s5 <= vc_s4;
		end
	end

	// stage 6: viscous term
	sat64_t rdu, rdv;
	logic signed [63:0] diffu_s6, diffv_s6, a12u_s6, a12v_s6;
	logic fl_s6;
	logic signed [DW-1:0] uc_s6, vc_s6;

	assign rdu = join_sat(96'(pdu_hi_s5), 96'(pdu_lo_s5));
	assign rdv = join_sat(96'(pdv_hi_s5), 96'(pdv_lo_s5));

	always_ff @(posedge clk) begin
		if (stg_en[5]) begin
			diffu_s6 <= rdu.val;
			diffv_s6 <= rdv.val;
			fl_s6 <= fl_s5 | rdu.ovf | rdv.ovf;
			a12u_s6 <= a12u_s5;
			a12v_s6 <= a12v_s5;
			uc_s6 <= uc_s5;
			vc_s6 <= vc_s5;
		end
	end

	// stage 7: right-hand side
	sat64_t rru, rrv;
	logic signed [63:0] rhsu_s7, rhsv_s7;
	logic fl_s7;
	logic signed [DW-1:0] uc_s7, vc_s7;

	assign rru = sat65(65'(diffu_s6) - 65'(a12u_s6));
	assign rrv = sat65(65'(diffv_s6) - 65'(a12v_s6));

	always_ff @(posedge clk) begin
		if (stg_en[6]) begin
			rhsu_s7 <= rru.val;
			rhsv_s7 <= rrv.val;
			fl_s7 <= fl_s6 | rru.ovf | rrv.ovf;
			uc_s7 <= uc_s6;
			vc_s7 <= vc_s6;
		end
	end

	// stage 8: time step partial products
	logic signed [32:0] ru_lo, rv_lo;
	logic signed [31:0] ru_hi, rv_hi;
	logic signed [64:0] pqu_lo_s8, pqv_lo_s8;
	logic signed [63:0] pqu_hi_s8, pqv_hi_s8;
	logic fl_s8;
	logic signed [DW-1:0] uc_s8, vc_s8;

	assign ru_lo = {1'b0, rhsu_s7[31:0]};
	assign ru_hi = rhsu_s7[63:32];
	assign rv_lo = {1'b0, rhsv_s7[31:0]};
	assign rv_hi = rhsv_s7[63:32];

	always_ff @(posedge clk) begin
		if (stg_en[7]) begin
			pqu_lo_s8 <= 65'(tstep_s) * 65'(ru_lo);
			pqu_hi_s8 <= 64'(tstep_s) * 64'(ru_hi);
			pqv_lo_s8 <= 65'(tstep_s) * 65'(rv_lo);
			pqv_hi_s8 <= 64'(tstep_s) * 64'(rv_hi);
			fl_s8 <= fl_s7;
			uc_s8 <= uc_s7;
			vc_s8 <= vc_s7;
		end
	end

	// stage 9: velocity increment
	sat64_t rqu, rqv;
	logic signed [63:0] qu_s9, qv_s9;
	logic fl_s9;
	logic signed [DW-1:0] uc_s9, vc_s9;

	assign rqu = join_sat(96'(pqu_hi_s8), 96'(pqu_lo_s8));
	assign rqv = join_sat(96'(pqv_hi_s8), 96'(pqv_lo_s8));

	always_ff @(posedge clk) begin
		if (stg_en[8]) begin
			qu_s9 <= rqu.val;
			qv_s9 <= rqv.val;
			fl_s9 <= fl_s8 | rqu.ovf | rqv.ovf;
			uc_s9 <= uc_s8;
			vc_s9 <= vc_s8;
		end
	end

	// stage 10: output register
	sat32_t rou, rov;
	logic signed [DW-1:0] upred_s10, vpred_s10;
	logic sat_s10;

	assign rou = sat_out(65'(uc_s9) + 65'(qu_s9));
	assign rov = sat_out(65'(vc_s9) + 65'(qv_s9));

	always_ff @(posedge clk) begin
		if (stg_en[9]) begin
			upred_s10 <= rou.val;
			vpred_s10 <= rov.val;
			sat_s10 <= fl_s9 | rou.ovf | rov.ovf;
		end
	end

	assign pred.u_pred = upred_s10;
	assign pred.v_pred = vpred_s10;
	assign pred.saturated = sat_s10;

endmodule
